>>> src/vertex_dedup_table_assert.svh
// Assertion helpers for the RTL file that checks its own logic.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef VERTEX_DEDUP_TABLE_ASSERT_SVH
`define VERTEX_DEDUP_TABLE_ASSERT_SVH

// Same-cycle implication, skipped while reset is held.
`define VDT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, skipped while reset is held.
`define VDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/vdt_pkg.sv
package vdt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int NUM_CELLS   = 16;
    localparam int CELL_DEPTH  = TABLE_DEPTH / NUM_CELLS;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CELL_W  = $clog2(NUM_CELLS);
    localparam int ROW_W   = $clog2(CELL_DEPTH);
    localparam int COORD_W = 32;
    localparam int TOL_W   = 16;
    localparam int PIDX_W  = 10;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd6;

    // Register index, taken from paddr[APB_AW-1]
    localparam logic REG_MATCH_TOL = 1'b0;

    // Match kinds
    localparam logic KIND_EXACT = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Token walking down the cell chain: one per scanned row
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [ROW_W-1:0] row;
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_tok;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_query;

    // Append bus, broadcast to all cells
    typedef struct packed {
        logic                      en;
        logic [CELL_W-1:0]         bank;
        logic [ROW_W-1:0]          row;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_wr;

endpackage

>>> src/vdt_in_if.sv
interface vdt_in_if;
    import vdt_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;

    modport source (output valid, output kind, output point_x, output point_y, input ready);
    modport sink   (input valid, input kind, input point_x, input point_y, output ready);
endinterface

>>> src/vdt_out_if.sv
interface vdt_out_if;
    import vdt_pkg::*;

    logic              valid;
    logic              ready;
    logic [PIDX_W-1:0] point_index;
    logic              was_added;
    logic              table_full;

    modport source (output valid, output point_index, output was_added, output table_full,
                    input ready);
    modport sink   (input valid, input point_index, input was_added, input table_full,
                    output ready);
endinterface

>>> src/vdt_cell.sv
module vdt_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [vdt_pkg::CELL_W-1:0] i_cell_id,
    input  logic [vdt_pkg::CNT_W-1:0] i_count,
    input  logic [vdt_pkg::TOL_W-1:0] i_tol,
    input  vdt_pkg::t_query           i_query,
    input  vdt_pkg::t_wr              i_wr,
    input  vdt_pkg::t_tok             i_tok,
    output vdt_pkg::t_tok             o_tok
);
    import vdt_pkg::*;

    logic [2*COORD_W-1:0] r_mem [CELL_DEPTH];
    logic [2*COORD_W-1:0] r_rd;
    t_tok                 r_tok_a;
    t_tok                 r_tok_b;

    logic                      w_we;
    logic signed [COORD_W-1:0] w_rx;
    logic signed [COORD_W-1:0] w_ry;
    logic signed [COORD_W:0]   w_tol_s;
    logic signed [COORD_W:0]   w_dx_sq;
    logic signed [COORD_W:0]   w_dx_qs;
    logic signed [COORD_W:0]   w_dy_sq;
    logic signed [COORD_W:0]   w_dy_qs;
    logic                      w_exact;
    logic                      w_close;
    logic [IDX_W-1:0]          w_idx;
    logic                      w_in_use;
    logic                      w_hit;

    assign w_we = i_wr.en && (i_wr.bank == i_cell_id);

    // Local slice of the table: entry row*NUM_CELLS + cell id
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[i_wr.row] <= {i_wr.x, i_wr.y};
        end
        if (i_tok.valid) begin
            r_rd <= r_mem[i_tok.row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_a <= '0;
        end else begin
            r_tok_a <= i_tok;
        end
    end

    assign w_rx    = r_rd[2*COORD_W-1:COORD_W];
    assign w_ry    = r_rd[COORD_W-1:0];
    assign w_tol_s = signed'((COORD_W+1)'(i_tol));

    // 33-bit differences both ways: |d| < t  <=>  d < t and -d < t
    assign w_dx_sq = {w_rx[COORD_W-1], w_rx} - {i_query.x[COORD_W-1], i_query.x};
    assign w_dx_qs = {i_query.x[COORD_W-1], i_query.x} - {w_rx[COORD_W-1], w_rx};
    assign w_dy_sq = {w_ry[COORD_W-1], w_ry} - {i_query.y[COORD_W-1], i_query.y};
    assign w_dy_qs = {i_query.y[COORD_W-1], i_query.y} - {w_ry[COORD_W-1], w_ry};

    assign w_exact = (w_rx == i_query.x) && (w_ry == i_query.y);
    assign w_close = (w_dx_sq < w_tol_s) && (w_dx_qs < w_tol_s) &&
                     (w_dy_sq < w_tol_s) && (w_dy_qs < w_tol_s);

    assign w_idx    = {r_tok_a.row, i_cell_id};
    assign w_in_use = CNT_W'(w_idx) < i_count;
    assign w_hit    = r_tok_a.valid && w_in_use &&
                      ((i_query.kind == KIND_CLOSE) ? w_close : w_exact);

    // Keep the earliest hit already on the token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_b <= '0;
        end else begin
            r_tok_b.valid <= r_tok_a.valid;
            r_tok_b.last  <= r_tok_a.last;
            r_tok_b.row   <= r_tok_a.row;
            r_tok_b.found <= r_tok_a.found || w_hit;
            r_tok_b.idx   <= r_tok_a.found ? r_tok_a.idx : w_idx;
        end
    end

    assign o_tok = r_tok_b;

endmodule

>>> src/vdt_chain.sv
module vdt_chain (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [vdt_pkg::CNT_W-1:0] i_count,
    input  logic [vdt_pkg::TOL_W-1:0] i_tol,
    input  vdt_pkg::t_query           i_query,
    input  vdt_pkg::t_wr              i_wr,
    input  vdt_pkg::t_tok             i_tok,
    output vdt_pkg::t_tok             o_tok
);
    import vdt_pkg::*;

    t_tok w_tok [NUM_CELLS+1];

    assign w_tok[0] = i_tok;

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        vdt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (CELL_W'(k)),
            .i_count   (i_count),
            .i_tol     (i_tol),
            .i_query   (i_query),
            .i_wr      (i_wr),
            .i_tok     (w_tok[k]),
            .o_tok     (w_tok[k+1])
        );
    end

    assign o_tok = w_tok[NUM_CELLS];

endmodule

>>> src/vertex_dedup_table.sv
// Channel  Dir  Payload                                   Handshake
// i_in     in   kind, point_x, point_y                    valid / ready
// o_out    out  point_index, was_added, table_full        valid / ready
// apb      in   match_tolerance at byte address 0         psel / penable, pready = 1
//
// One item at a time: the input is ready only in the idle state, which follows the loading
// of the result into the output register. For each search
// R = max(1, ceil(entry_count / NUM_CELLS)) rows are fed into the cell chain one
// per cycle and each of the NUM_CELLS cells adds a read stage and a compare stage.
// A finished result waits in the output register; the next item may be accepted
// meanwhile and stalls only at its own result if the old one is still not taken.
// Reset is synchronous, active low; it empties the table and sets the tolerance to 6.
`include "vertex_dedup_table_assert.svh"

module vertex_dedup_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    vdt_in_if.sink                      i_in,
    vdt_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vdt_pkg::APB_AW-1:0]  paddr,
    input  logic [vdt_pkg::APB_DW-1:0]  pwdata,
    output logic [vdt_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import vdt_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [ROW_W-1:0]  r_row;
    logic [CNT_W-1:0]  r_count;
    logic [TOL_W-1:0]  r_tol;
    t_query            r_query;
    logic              r_found;
    logic [IDX_W-1:0]  r_idx;
    logic              r_out_valid;
    logic [PIDX_W-1:0] r_out_idx;
    logic              r_out_added;
    logic              r_out_full;

    logic              w_in_acc;
    logic              w_cfg_wr;
    logic              w_full;
    logic [CNT_W-1:0]  w_cnt_m1;
    logic [ROW_W-1:0]  w_last_row;
    logic              w_load;
    t_tok              w_issue;
    t_tok              w_tail;
    t_wr               w_wr;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;

    // Config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[APB_AW-1] == REG_MATCH_TOL) ? APB_DW'(r_tol) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (w_cfg_wr && (paddr[APB_AW-1] == REG_MATCH_TOL)) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    assign w_full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_cnt_m1   = r_count - 1'b1;
    assign w_last_row = (r_count == '0) ? '0 : w_cnt_m1[IDX_W-1:CELL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_issue = '0;
        w_load  = 1'b0;
        w_wr    = '0;
        w_wr.bank = r_count[CELL_W-1:0];
        w_wr.row  = r_count[IDX_W-1:CELL_W];
        w_wr.x    = r_query.x;
        w_wr.y    = r_query.y;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                w_issue.valid = 1'b1;
                w_issue.row   = r_row;
                w_issue.last  = (r_row == w_last_row);
                if (w_issue.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_tail.valid && w_tail.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load  = 1'b1;
                    w_wr.en = !r_found && !w_full;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Row counter and query hold
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_row         <= '0;
            r_query.kind  <= i_in.kind;
            r_query.x     <= i_in.point_x;
            r_query.y     <= i_in.point_y;
        end else if (r_state == S_SCAN) begin
            r_row <= r_row + 1'b1;
        end
    end

    // Tokens leave the chain in row order: take the first one that found a hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (w_in_acc) begin
            r_found <= 1'b0;
        end else if (w_tail.valid && w_tail.found && !r_found) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail.valid && w_tail.found && !r_found) begin
            r_idx <= w_tail.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_wr.en) begin
            r_count <= r_count + 1'b1;
        end
    end

    vdt_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_count (r_count),
        .i_tol   (r_tol),
        .i_query (r_query),
        .i_wr    (w_wr),
        .i_tok   (w_issue),
        .o_tok   (w_tail)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_idx   <= r_found ? PIDX_W'(r_idx) : (w_full ? '0 : PIDX_W'(r_count));
            r_out_added <= !r_found && !w_full;
            r_out_full  <= !r_found && w_full;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.point_index = r_out_idx;
    assign o_out.was_added   = r_out_added;
    assign o_out.table_full  = r_out_full;

    `VDT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(TABLE_DEPTH), "entry count over depth")
    `VDT_ASSERT_NEXT(a_accept_scan, w_in_acc, r_state == S_SCAN, "accepted item did not start scan")
    `VDT_ASSERT_NOW(a_tail_busy, w_tail.valid, (r_state == S_SCAN) || (r_state == S_DRAIN), "chain token outside a search")
    `VDT_ASSERT_NEXT(a_append_count, w_wr.en, r_count == $past(r_count) + 1'b1, "append did not bump count")
    `VDT_ASSERT_NOW(a_result_kind, o_out.valid, !(o_out.was_added && o_out.table_full), "result both added and full")

endmodule
